>>> hdl/huffman_code_bit_packer_defines.svh
// ---------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Assertion helpers for the code bit packer; they fold away in synthesis.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset
`define HCBP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition in this cycle implies a condition in the next cycle
`define HCBP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HCBP_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define HCBP_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

>>> hdl/hcbp_pkg.sv
// ---------------------------------------------------------------------------
// Huffman code bit packer package
// Field widths, parameter defaults and request mode codes.
// ---------------------------------------------------------------------------
package hcbp_pkg;

  // Request field widths
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 16;
  localparam int LEN_IN_W   = 5;
  localparam int MODE_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int IN_TDATA_W = 32;

  // Parameter defaults
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 16;

  // Request kinds carried on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

endpackage

>>> hdl/hcbp_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; hold read data while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/huffman_code_bit_packer.sv
// ---------------------------------------------------------------------------
// Huffman code bit packer
// Loads a code table and packs looked-up codes MSB first into output bytes.
// ---------------------------------------------------------------------------
//
//  port group  | dir | payload
//  ------------+-----+------------------------------------------------------
//  s_axis_*    | in  | tuser: mode; tdata: symbol, code_bits, code_length
//  m_axis_*    | out | tdata: out_byte; tlast: last byte of the request
//
//  A request is taken every cycle while the result queue has room. The code
//  table RAM is read in the accept cycle; the packer merges the registered
//  entry in stage 1 and pushes its bytes into the result queue, whose head
//  drives m_axis. The single output byte per cycle sets the sustained rate:
//  one request per cycle for requests giving up to one byte while m_axis is
//  ready; symbols that complete two bytes are limited by the output sending
//  both. Reset clears stage 1, the packer and the queue and holds the input
//  off; the table holds no reset state. Back-pressure fills the four-entry queue.
//
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] symbol, [23:8] code_bits, [28:24] code_length, [31:29] zero
  input  logic [hcbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [hcbp_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] out_byte
  output logic [hcbp_pkg::BYTE_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast
);

  import hcbp_pkg::*;

  localparam int ADDR_W     = $clog2(SYMBOL_COUNT);
  localparam int LEN_LIMIT  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LEN_W      = $clog2(LEN_LIMIT + 1);
  localparam int ENTRY_W    = CODE_W + LEN_W;
  localparam int ACC_W      = CODE_W + BYTE_W;
  localparam int CNT_W      = $clog2(BYTE_W + 1);
  localparam int TOT_W      = $clog2(ACC_W + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int RES_W      = BYTE_W + 1;

  // Request fields
  logic [SYM_W-1:0]    in_symbol;
  logic [CODE_W-1:0]   in_code_bits;
  logic [LEN_IN_W-1:0] in_code_length;
  mode_t               in_mode;
  logic                in_accept;
  logic                in_hit;
  logic [LEN_IN_W-1:0] sat_len;
  logic [CODE_W-1:0]   load_code;

  // Stage 1 and packer state
  logic                s1_valid;
  mode_t               s1_mode;
  logic                s1_hit;
  logic                s1_go;
  logic [ENTRY_W-1:0]  rd_data;
  logic [CODE_W-1:0]   e_code;
  logic [LEN_W-1:0]    e_len;
  logic [BYTE_W-1:0]   pack_byte;
  logic [BYTE_W-1:0]   pack_byte_next;
  logic [CNT_W-1:0]    pack_count;
  logic [CNT_W-1:0]    pack_count_next;
  logic [ACC_W-1:0]    acc;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_m1;
  logic [1:0]          nbytes;

  // Result queue
  logic [RES_W-1:0]    fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [FCNT_W-1:0]   fifo_count;
  logic [1:0]          push_n;
  logic [RES_W-1:0]    slot0;
  logic [RES_W-1:0]    slot1;
  logic                pop;

  // Unpack request
  assign in_symbol      = s_axis_tdata[SYM_W-1:0];
  assign in_code_bits   = s_axis_tdata[SYM_W +: CODE_W];
  assign in_code_length = s_axis_tdata[SYM_W+CODE_W +: LEN_IN_W];
  assign in_mode        = mode_t'(s_axis_tuser);
  assign in_accept      = s_axis_tvalid && s_axis_tready;
  assign in_hit         = ({1'b0, in_symbol} < (SYM_W+1)'(SYMBOL_COUNT));

  // Saturate the code length and clear code bits beyond it
  assign sat_len   = (in_code_length > LEN_IN_W'(LEN_LIMIT)) ? LEN_IN_W'(LEN_LIMIT)
                                                             : in_code_length;
  assign load_code = in_code_bits & ~({CODE_W{1'b1}} >> sat_len);

  // Code table: write on load, read on every accepted request
  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (in_accept && in_hit && (in_mode == MODE_LOAD)),
    .waddr (in_symbol[ADDR_W-1:0]),
    .wdata ({LEN_W'(sat_len), load_code}),
    .re    (in_accept),
    .raddr (in_symbol[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Advance stage 1 while the queue has room for two bytes; hold off in reset
  assign s1_go         = s1_valid && (fifo_count <= FCNT_W'(FIFO_DEPTH - 2));
  assign s_axis_tready = !rst && (!s1_valid || s1_go);

  // Merge the looked-up code behind the collected bits
  assign e_code   = rd_data[CODE_W-1:0];
  assign e_len    = rd_data[CODE_W +: LEN_W];
  assign acc      = {pack_byte, {CODE_W{1'b0}}} | ({e_code, {BYTE_W{1'b0}}} >> pack_count);
  assign total    = TOT_W'(pack_count) + TOT_W'(e_len);
  assign total_m1 = total - TOT_W'(1);
  assign nbytes   = total_m1[TOT_W-1:3];

  // Packer next state and results
  always_comb begin
    pack_byte_next  = pack_byte;
    pack_count_next = pack_count;
    push_n          = 2'd0;
    slot0           = {acc[ACC_W-1 -: BYTE_W], 1'b1};
    slot1           = {acc[ACC_W-BYTE_W-1 -: BYTE_W], 1'b1};
    if (s1_go) begin
      unique case (s1_mode)
        MODE_ENCODE: begin
          if (s1_hit && (e_len != '0)) begin
            push_n          = nbytes;
            slot0           = {acc[ACC_W-1 -: BYTE_W], (nbytes == 2'd1)};
            pack_count_next = CNT_W'(total - {nbytes, 3'b000});
            case (nbytes)
              2'd0:    pack_byte_next = acc[ACC_W-1 -: BYTE_W];
              2'd1:    pack_byte_next = acc[ACC_W-BYTE_W-1 -: BYTE_W];
              default: pack_byte_next = acc[BYTE_W-1:0];
            endcase
          end
        end
        MODE_FLUSH: begin
          push_n          = 2'd1;
          slot0           = {pack_byte, 1'b1};
          pack_byte_next  = '0;
          pack_count_next = '0;
        end
        default: begin
          push_n = 2'd0;
        end
      endcase
    end
  end

  // Stage 1 control and packer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pack_byte  <= '0;
      pack_count <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      pack_byte  <= pack_byte_next;
      pack_count <= pack_count_next;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode <= in_mode;
      s1_hit  <= in_hit;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= slot0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + PTR_W'(1)] <= slot1;
    end
  end

  // Queue pointers and fill count
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_count <= fifo_count + FCNT_W'(push_n) - FCNT_W'(pop);
    end
  end

  // Present the queue head
  assign m_axis_tvalid = (fifo_count != '0);
  assign m_axis_tdata  = fifo_mem[rd_ptr][RES_W-1:1];
  assign m_axis_tlast  = fifo_mem[rd_ptr][0];

  // Checks
  `HCBP_ASSERT_ALWAYS(a_fifo_bound, clk, rst, fifo_count <= FCNT_W'(FIFO_DEPTH), "result queue overflow")
  `HCBP_ASSERT_ALWAYS(a_pack_bound, clk, rst, pack_count <= CNT_W'(BYTE_W), "packer holds more than a byte")
  `HCBP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_go, s1_valid && $stable(s1_mode) && $stable(s1_hit), "stalled stage 1 lost its request")
  `HCBP_ASSERT_NEXT(a_flush_clear, clk, rst, s1_go && (s1_mode == MODE_FLUSH), (pack_count == '0) && (pack_byte == '0), "flush left bits in the packer")

endmodule

>>> sim/tb_huffman_code_bit_packer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Huffman code bit packer testbench
// Loads code table entries, encodes loaded symbols, flushes the packer and
// sends unused modes. Each output byte and its tlast flag is compared with
// a behavioural packer that tracks the table and the byte being filled, or
// with typed-in results. A directed table comes first, then randomised
// traffic with bursts of idling on both streams and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 450;
  localparam int QUIET_TAIL    = 60;
  localparam int HOLD_AT_ITEM  = 200;
  localparam int HOLD_CYCLES   = 64;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LEN_CAP       = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
  localparam int PLAN_ROWS     = 17;
  // mode code outside the defined set; the block ignores it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // one table entry: MSB-aligned code word and its length
  typedef struct packed {
    logic [CODE_W-1:0]   word;
    logic [LEN_IN_W-1:0] len;
  } code_entry_t;

  // one output byte with its end-of-request flag
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } out_byte_t;

  // directed stimulus row, with typed-in results where they are obvious
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SYM_W-1:0]    sym;
    logic [CODE_W-1:0]   bits;
    logic [LEN_IN_W-1:0] len;
    logic                typed;
    logic [1:0]          count;
    logic [BYTE_W-1:0]   b0;
    logic [BYTE_W-1:0]   b1;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = MODE_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;

  // behavioural packer state
  code_entry_t       code_book [SYMBOL_COUNT_DEF];
  logic [BYTE_W-1:0] fill_byte = '0;
  logic [3:0]        fill_count = '0;

  out_byte_t expected_bytes [$];
  bit        loaded [SYMBOL_COUNT_DEF];
  int        loaded_syms [$];
  plan_row_t plan [PLAN_ROWS];

  int  error_count = 0;
  int  bytes_checked = 0;
  int  loads_sent = 0;
  int  encodes_sent = 0;
  int  flushes_sent = 0;
  int  quiet_cycles = 0;
  bit  idling_on = 1'b1;
  bit  long_hold_pending = 1'b0;

  huffman_code_bit_packer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Work out the bytes one request produces and advance the packer state
  function automatic int pack_request_bytes(input logic [MODE_W-1:0] mode,
                                            input logic [SYM_W-1:0] sym,
                                            input logic [CODE_W-1:0] bits,
                                            input logic [LEN_IN_W-1:0] len,
                                            output logic [1:0][BYTE_W-1:0] bytes);
    int          n;
    int          span;
    code_entry_t entry;
    n = 0;
    bytes = '0;
    case (mode)
      MODE_LOAD: begin
        span = (int'(len) > LEN_CAP) ? LEN_CAP : int'(len);
        entry.word = bits;
        entry.len = LEN_IN_W'(span);
        code_book[sym] = entry;
      end
      MODE_ENCODE: begin
        entry = code_book[sym];
        span = (int'(entry.len) > LEN_CAP) ? LEN_CAP : int'(entry.len);
        // shift code bits in first bit first; a full byte leaves on the next bit
        for (int i = 0; i < span; i++) begin
          if (fill_count >= 4'd8) begin
            bytes[n] = fill_byte;
            n++;
            fill_byte = '0;
            fill_count = '0;
          end
          if (entry.word[CODE_W-1-i])
            fill_byte[7-fill_count] = 1'b1;
          fill_count++;
        end
      end
      MODE_FLUSH: begin
        bytes[n] = fill_byte;
        n++;
        fill_byte = '0;
        fill_count = '0;
      end
      default: ;
    endcase
    return n;
  endfunction

  // Offer one request, hold it until taken, then log what it should produce
  task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                               input logic [CODE_W-1:0] bits, input logic [LEN_IN_W-1:0] len,
                               input bit typed, input int typed_count,
                               input logic [1:0][BYTE_W-1:0] typed_bytes);
    logic [1:0][BYTE_W-1:0] bytes;
    int                     n;
    out_byte_t              entry;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, len, bits, sym};
    do @(posedge clk); while (!s_axis_tready);
    n = pack_request_bytes(mode, sym, bits, len, bytes);
    if (typed) begin
      n = typed_count;
      bytes = typed_bytes;
    end
    for (int k = 0; k < n; k++) begin
      entry.value = bytes[k];
      entry.last = (k == n - 1);
      expected_bytes.push_back(entry);
    end
    case (mode)
      MODE_LOAD: begin
        loads_sent++;
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(int'(sym));
        end
      end
      MODE_ENCODE: encodes_sent++;
      MODE_FLUSH: flushes_sent++;
      default: ;
    endcase
  endtask

  // Drop valid for a short random burst now and then
  task automatic maybe_idle_sender();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    logic [MODE_W-1:0]   mode;
    logic [SYM_W-1:0]    sym;
    logic [CODE_W-1:0]   bits;
    logic [LEN_IN_W-1:0] len;
    int                  pick;
    int                  counted;
    int                  idx;

    plan = '{
      // empty flush gives a single zero byte
      '{MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b1, 2'd1, 8'h00, 8'h00},
      '{MODE_LOAD,   8'h00, 16'hFFFF, 5'd16, 1'b1, 2'd0, 8'h00, 8'h00},
      // long code saturates to the word width
      '{MODE_LOAD,   8'hFF, 16'h0000, 5'd31, 1'b1, 2'd0, 8'h00, 8'h00},
      '{MODE_LOAD,   8'h01, 16'hA000, 5'd3,  1'b0, 2'd0, 8'h00, 8'h00},
      '{MODE_LOAD,   8'h02, 16'h1234, 5'd0,  1'b1, 2'd0, 8'h00, 8'h00},
      // sixteen ones: first byte leaves, second stays full in the packer
      '{MODE_ENCODE, 8'h00, 16'h0000, 5'd0,  1'b1, 2'd1, 8'hFF, 8'h00},
      // sixteen zeros push out the held byte and one more
      '{MODE_ENCODE, 8'hFF, 16'h0000, 5'd0,  1'b1, 2'd2, 8'hFF, 8'h00},
      // zero-length code emits nothing
      '{MODE_ENCODE, 8'h02, 16'h0000, 5'd0,  1'b1, 2'd0, 8'h00, 8'h00},
      '{MODE_ENCODE, 8'h01, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00},
      '{MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00},
      // unused mode is ignored, all field bits high
      '{MODE_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 1'b1, 2'd0, 8'h00, 8'h00},
      '{MODE_LOAD,   8'h80, 16'h5555, 5'd17, 1'b0, 2'd0, 8'h00, 8'h00},
      '{MODE_ENCODE, 8'h80, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00},
      // flush of a full byte
      '{MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00},
      '{MODE_LOAD,   8'hAA, 16'hFFFF, 5'd1,  1'b0, 2'd0, 8'h00, 8'h00},
      '{MODE_ENCODE, 8'hAA, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00},
      '{MODE_FLUSH,  8'h00, 16'h0000, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      issue_request(plan[i].mode, plan[i].sym, plan[i].bits, plan[i].len,
                    plan[i].typed, int'(plan[i].count), {plan[i].b1, plan[i].b0});
      maybe_idle_sender();
    end

    // random traffic; ignored requests do not count
    counted = 0;
    idx = 0;
    while (counted < RANDOM_ITEMS) begin
      idling_on = (counted < RANDOM_ITEMS - QUIET_TAIL) && !((idx % 120) inside {[60:79]});
      if (idx == HOLD_AT_ITEM)
        long_hold_pending = 1'b1;
      pick = $urandom_range(0, 99);
      sym  = '0;
      bits = '0;
      len  = '0;
      if (pick < 25 || loaded_syms.size() == 0) begin
        mode = MODE_LOAD;
        sym  = SYM_W'($urandom_range(0, 255));
        bits = CODE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)
          len = LEN_IN_W'($urandom_range(1, 16));
        else if (pick < 80)
          len = '0;
        else
          len = LEN_IN_W'($urandom_range(17, 31));
      end else if (pick < 85) begin
        mode = MODE_ENCODE;
        sym  = SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      end else if (pick < 96) begin
        mode = MODE_FLUSH;
        sym  = SYM_W'($urandom_range(0, 255));
      end else begin
        mode = MODE_UNUSED;
        sym  = SYM_W'($urandom_range(0, 255));
        bits = CODE_W'($urandom);
        len  = LEN_IN_W'($urandom_range(0, 31));
      end
      issue_request(mode, sym, bits, len, 1'b0, 0, '0);
      if (mode != MODE_UNUSED)
        counted++;
      idx++;
      maybe_idle_sender();
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for anything late
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d encodes and %0d flushes; %0d output bytes checked.",
             loads_sent, encodes_sent, flushes_sent, bytes_checked);
    $display("Long codes, zero-length codes, empty and full flushes and the unused mode included.");
    if (error_count == 0) begin
      $display("huffman_code_bit_packer verification clean");
    end else begin
      $display("huffman_code_bit_packer verification failed");
    end
    $finish;
  end

  // Output ready: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output byte with the oldest expectation
  always @(posedge clk) begin
    out_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected byte: expected none, actual tdata=%02h tlast=%0b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.value) begin
          error_count++;
          $display("%0t: tdata mismatch: expected %02h, actual %02h",
                   $time, want.value, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          error_count++;
          $display("%0t: tlast mismatch: expected %0b, actual %0b",
                   $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or byte moved for %0d cycles, %0d bytes outstanding",
               $time, STALL_LIMIT, expected_bytes.size());
      $display("huffman_code_bit_packer verification failed");
      $finish;
    end
  end

endmodule

>>> files.f
+incdir+hdl
hdl/hcbp_pkg.sv
hdl/hcbp_ram.sv
hdl/huffman_code_bit_packer.sv
sim/tb_huffman_code_bit_packer.sv
